@@ rtl/prc_pkg.sv @@
// Shared types, constants and helper functions of the path risk classifier.
// Depends on nothing; cell, prefix and top files refer to it by scoped names.
`timescale 1ns / 1ps

package prc_pkg;

	// Default depth of the recent-character window.
	localparam int WINDOW_CHARS = 13;

	// Character codes that the control logic tests for.
	localparam logic [15:0] CH_NUL    = 16'h0000;
	localparam logic [15:0] CH_COLON  = 16'h003A;
	localparam logic [15:0] CH_BSLASH = 16'h005C;

	// Position counter width and its saturation value.
	localparam int POS_W = 5;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// Start-of-path prefixes for remote and optical devices.
	localparam int NUM_PREFIXES = 6;
	localparam int PREFIX_BYTES = 26;
	localparam logic [8*PREFIX_BYTES-1:0] PREFIX_TXT [NUM_PREFIXES] = '{
		{"\\device\\m", "up\\"},
		{"\\device\\lanman", "redirector\\"},
		{"\\device\\webdav", "redirector\\"},
		{"\\??", "\\unc\\"},
		{"\\??\\globalroot\\device\\m", "up\\"},
		{"\\device\\cdrom"}
	};
	localparam int PREFIX_LEN [NUM_PREFIXES] = '{12, 25, 25, 8, 26, 13};

	// Patterns that may end anywhere in the path, matched over the window.
	localparam int TAIL_BYTES = 14;
	localparam int NUM_TRAV = 4;
	localparam logic [8*TAIL_BYTES-1:0] TRAV_TXT [NUM_TRAV] = '{
		{"\\..\\"}, {"/../"}, {"\\.\\"}, {"/./"}
	};
	localparam int TRAV_LEN [NUM_TRAV] = '{4, 4, 3, 3};

	localparam int NUM_CLOUD = 7;
	localparam logic [8*TAIL_BYTES-1:0] CLOUD_TXT [NUM_CLOUD] = '{
		{"\\one", "drive\\"},
		{"\\drop", "box\\"},
		{"\\google", " drive\\"},
		{"\\google", "drive\\"},
		{"\\icloud", " drive\\"},
		{"\\box\\"},
		{"\\sync", "thing\\"}
	};
	localparam int CLOUD_LEN [NUM_CLOUD] = '{10, 9, 14, 13, 14, 5, 11};

	// Control word that steps the window cells.
	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

	// ASCII-only case folding.
	function automatic logic [15:0] fold_unit(input logic [15:0] c);
		if (c >= 16'h0041 && c <= 16'h005A) begin
			return c + 16'd32;
		end
		return c;
	endfunction

	// True for an ASCII letter of either case.
	function automatic logic is_letter(input logic [15:0] c);
		return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
	endfunction

endpackage

@@ rtl/prc_if.sv @@
// Handshake channels of the path risk classifier: path characters in, verdicts out.
// Depends on nothing else; both interfaces carry valid, ready and the payload.
`timescale 1ns / 1ps

interface prc_path_if;
	logic        valid;
	logic        ready;
	logic [15:0] path_char;
	logic        last_char;

	modport source (output valid, path_char, last_char, input ready);
	modport sink (input valid, path_char, last_char, output ready);
endinterface

interface prc_verdict_if;
	logic valid;
	logic ready;
	logic high_risk;
	logic has_traversal;
	logic has_stream_colon;
	logic remote_prefix;
	logic cloud_marker;

	modport source (output valid, high_risk, has_traversal, has_stream_colon,
		remote_prefix, cloud_marker, input ready);
	modport sink (input valid, high_risk, has_traversal, has_stream_colon,
		remote_prefix, cloud_marker, output ready);
endinterface

@@ rtl/prc_cell.sv @@
// One cell of the recent-character window: holds a folded character and
// passes it to the next cell on each shift. Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  prc_pkg::win_ctrl_t  ctrl,
	input  logic [15:0]         d,
	output logic [15:0]         q
);

	logic [15:0] char_q;

	// Clear at the end of a path, otherwise take the character at d on a shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
		end else if (ctrl.clear) begin
			char_q <= '0;
		end else if (ctrl.shift) begin
			char_q <= d;
		end
	end

	assign q = char_q;

endmodule

@@ rtl/prc_prefix.sv @@
// Tracker for one start-of-path prefix: compares each character against the
// prefix at the current position. Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_prefix #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  prc_pkg::win_ctrl_t          ctrl,
	input  logic [prc_pkg::POS_W-1:0]   pos,
	input  logic [15:0]                 f,
	output logic                        hit_nxt
);

	localparam int LEN = prc_pkg::PREFIX_LEN[IDX];
	localparam logic [8*prc_pkg::PREFIX_BYTES-1:0] TXT = prc_pkg::PREFIX_TXT[IDX];

	logic       alive_q;
	logic       hit_q;
	logic [7:0] expect_byte;
	logic       in_range;
	logic       at_end;
	logic       char_eq;

	// Select the expected character at the current position.
	always_comb begin
		expect_byte = '0;
		for (int k = 0; k < LEN; k++) begin
			if (pos == k[prc_pkg::POS_W-1:0]) begin
				expect_byte = TXT[8*(LEN-1-k) +: 8];
			end
		end
	end

	assign in_range = pos < LEN[prc_pkg::POS_W-1:0];
	assign at_end   = pos == LEN[prc_pkg::POS_W-1:0] - 1'b1;
	assign char_eq  = f == {8'h00, expect_byte};
	assign hit_nxt  = hit_q | (ctrl.shift & alive_q & in_range & char_eq & at_end);

	// The prefix dies on the first mismatch and hits when its last character matches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b1;
			hit_q   <= 1'b0;
		end else if (ctrl.clear) begin
			alive_q <= 1'b1;
			hit_q   <= 1'b0;
		end else if (ctrl.shift && alive_q && in_range) begin
			if (!char_eq) begin
				alive_q <= 1'b0;
			end else if (at_end) begin
				hit_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/path_risk_pattern_classifier.sv @@
// Path risk classifier: takes one path character per cycle while the output
// register can drain, and gives a verdict once the last one is accepted. The
// verdict appears in the output register in the cycle after the last character
// is accepted. Reset clears the window, the prefix trackers and the per-path
// flags; the same clear happens after every verdict.
// Depends on prc_pkg, prc_if, prc_cell and prc_prefix.
`timescale 1ns / 1ps

module path_risk_pattern_classifier #(
	parameter int WINDOW_CHARS = prc_pkg::WINDOW_CHARS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	prc_path_if.sink              path_in,
	prc_verdict_if.source         verdict_out
);

	localparam int NUM_P = prc_pkg::NUM_PREFIXES;

	logic [15:0]                c;
	logic [15:0]                f;
	logic                       accept;
	logic                       take;
	logic                       done;
	prc_pkg::win_ctrl_t         ctrl;

	logic                       ended_q;
	logic [15:0]                prev_q;
	logic [prc_pkg::POS_W-1:0]  pos_q;
	logic [2:0]                 flags_q;
	logic [2:0]                 flags_nxt;

	logic [15:0]                win [WINDOW_CHARS];
	logic [NUM_P-1:0]           prefix_hit;
	logic [prc_pkg::NUM_TRAV-1:0]  trav_match;
	logic [prc_pkg::NUM_CLOUD-1:0] cloud_match;
	logic                       colon_hit;
	logic                       remote;

	logic                       out_valid_q;
	logic                       trav_q;
	logic                       colon_q;
	logic                       remote_q;
	logic                       cloud_q;

	// Input handshake: a new word is taken whenever the output register can drain.
	assign path_in.ready = !out_valid_q || verdict_out.ready;
	assign accept        = path_in.valid && path_in.ready;
	assign c             = path_in.path_char;
	assign f             = prc_pkg::fold_unit(c);
	assign take          = accept && !ended_q && (c != prc_pkg::CH_NUL);
	assign done          = accept && path_in.last_char;
	assign ctrl.shift    = take;
	assign ctrl.clear    = done;

	// Row of window cells; cell 0 holds the newest folded character.
	generate
		for (genvar i = 0; i < WINDOW_CHARS; i++) begin : g_cell
			if (i == 0) begin : g_head
				prc_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctrl   (ctrl),
					.d      (f),
					.q      (win[i])
				);
			end else begin : g_body
				prc_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctrl   (ctrl),
					.d      (win[i-1]),
					.q      (win[i])
				);
			end
		end
	endgenerate

	// One tracker per start-of-path prefix.
	generate
		for (genvar p = 0; p < NUM_P; p++) begin : g_prefix
			prc_prefix #(
				.IDX (p)
			) u_prefix (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.pos     (pos_q),
				.f       (f),
				.hit_nxt (prefix_hit[p])
			);
		end
	endgenerate

	assign remote = |prefix_hit;

	// Patterns that end at the current character, checked against the window.
	always_comb begin
		for (int t = 0; t < prc_pkg::NUM_TRAV; t++) begin
			trav_match[t] = (prc_pkg::TRAV_LEN[t] - 1 <= WINDOW_CHARS) &&
				(f == {8'h00, prc_pkg::TRAV_TXT[t][7:0]});
			for (int k = 1; k < prc_pkg::TAIL_BYTES; k++) begin
				if (k < prc_pkg::TRAV_LEN[t] && k <= WINDOW_CHARS) begin
					if (win[k-1] != {8'h00, prc_pkg::TRAV_TXT[t][8*k +: 8]}) begin
						trav_match[t] = 1'b0;
					end
				end
			end
		end
		for (int n = 0; n < prc_pkg::NUM_CLOUD; n++) begin
			cloud_match[n] = (prc_pkg::CLOUD_LEN[n] - 1 <= WINDOW_CHARS) &&
				(f == {8'h00, prc_pkg::CLOUD_TXT[n][7:0]});
			for (int k = 1; k < prc_pkg::TAIL_BYTES; k++) begin
				if (k < prc_pkg::CLOUD_LEN[n] && k <= WINDOW_CHARS) begin
					if (win[k-1] != {8'h00, prc_pkg::CLOUD_TXT[n][8*k +: 8]}) begin
						cloud_match[n] = 1'b0;
					end
				end
			end
		end
	end

	// A colon names a stream unless it is a drive colon or follows a backslash.
	assign colon_hit = take && (c == prc_pkg::CH_COLON) &&
		!(pos_q == prc_pkg::POS_W'(1) && prc_pkg::is_letter(prev_q)) &&
		(prev_q != prc_pkg::CH_BSLASH);

	assign flags_nxt = flags_q | {take && (|cloud_match), colon_hit, take && (|trav_match)};

	// Per-path control state, cleared after each verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
			prev_q  <= '0;
			pos_q   <= '0;
			flags_q <= '0;
		end else if (done) begin
			ended_q <= 1'b0;
			prev_q  <= '0;
			pos_q   <= '0;
			flags_q <= '0;
		end else if (accept) begin
			if (take) begin
				prev_q  <= c;
				flags_q <= flags_nxt;
				if (pos_q != prc_pkg::POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (!ended_q) begin
				ended_q <= 1'b1;
			end
		end
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Verdict payload, loaded with the last character.
	always_ff @(posedge clk) begin
		if (done) begin
			trav_q   <= flags_nxt[0];
			colon_q  <= flags_nxt[1];
			cloud_q  <= flags_nxt[2];
			remote_q <= remote;
		end
	end

	assign verdict_out.valid            = out_valid_q;
	assign verdict_out.has_traversal    = trav_q;
	assign verdict_out.has_stream_colon = colon_q;
	assign verdict_out.remote_prefix    = remote_q;
	assign verdict_out.cloud_marker     = cloud_q;
	assign verdict_out.high_risk        = trav_q | colon_q | remote_q | cloud_q;

endmodule
